// ----- sv/chrt_pkg.sv -----
// shared types, constants and helpers for the consistent hash ring table
`default_nettype none
package chrt_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int HASH_W = 64;
    localparam int TAG_W = 16;
    localparam int CFG_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd1125899906842597;
    localparam logic [HASH_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLICA = 1'b1;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic [CFG_W-1:0] REPLICA_RESET = 5'd3;

    typedef struct packed {
        logic              func;
        logic [HASH_W-1:0] hash;
        logic [TAG_W-1:0]  tag;
    } req_t;

    // signed order compare done as unsigned on sign-flipped keys
    function automatic logic key_lt(input logic [HASH_W-1:0] a, input logic [HASH_W-1:0] b);
        key_lt = (a ^ SIGN_BIT) < (b ^ SIGN_BIT);
    endfunction

endpackage
`default_nettype wire

// ----- sv/chrt_front.sv -----
// front end: running string hash and request hand-off on the last byte
`default_nettype none
module chrt_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        func,
    input  wire logic [7:0]                  key_byte,
    input  wire logic                        last_byte,
    input  wire logic [chrt_pkg::TAG_W-1:0]  slave_tag,
    input  wire logic                        q_full,
    output logic                             q_push,
    output chrt_pkg::req_t                   q_req
);

    logic [chrt_pkg::HASH_W-1:0] hash_reg;
    logic [chrt_pkg::HASH_W-1:0] hash_next;
    logic [chrt_pkg::HASH_W-1:0] hash_upd;
    logic                        accept;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;

    // h * 31 + sign-extended byte
    assign hash_upd = {hash_reg[chrt_pkg::HASH_W-6:0], 5'b0} - hash_reg
                      + {{(chrt_pkg::HASH_W-8){key_byte[7]}}, key_byte};

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = last_byte ? chrt_pkg::HASH_SEED : hash_upd;
        end
    end

    assign q_push = accept && last_byte;
    assign q_req.func = func;
    assign q_req.hash = hash_upd;
    assign q_req.tag = slave_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= chrt_pkg::HASH_SEED;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/chrt_queue.sv -----
// short request queue between the front end and the table engine
`default_nettype none
module chrt_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire chrt_pkg::req_t push_req,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output chrt_pkg::req_t     head
);

    chrt_pkg::req_t                 entries_reg [chrt_pkg::QUEUE_DEPTH];
    logic [chrt_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [chrt_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [chrt_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [chrt_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [chrt_pkg::QCNT_W-1:0]    cnt_reg;
    logic [chrt_pkg::QCNT_W-1:0]    cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign full = (cnt_reg == chrt_pkg::QCNT_W'(chrt_pkg::QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule
`default_nettype wire

// ----- sv/chrt_back.sv -----
// table engine: sorted insert, ring lookup and result output register
`default_nettype none
module chrt_back
#(
    parameter int MAX_ENTRIES = chrt_pkg::MAX_ENTRIES_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [chrt_pkg::CFG_W-1:0]        table_capacity,
    input  wire logic [chrt_pkg::CFG_W-1:0]        replica_count,
    input  wire logic                              q_valid,
    input  wire chrt_pkg::req_t                    q_req,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic [chrt_pkg::TAG_W-1:0]             entry_tag,
    output logic signed [chrt_pkg::HASH_W-1:0]     entry_id,
    output logic                                   last_result
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > chrt_pkg::CFG_W) ? CW : chrt_pkg::CFG_W;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_START = 10'b00_0000_0010,
        ST_SRCH  = 10'b00_0000_0100,
        ST_SHRD  = 10'b00_0000_1000,
        ST_SHWR  = 10'b00_0001_0000,
        ST_WRITE = 10'b00_0010_0000,
        ST_RESP  = 10'b00_0100_0000,
        ST_SCAN  = 10'b00_1000_0000,
        ST_LRD   = 10'b01_0000_0000,
        ST_LOUT  = 10'b10_0000_0000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [CW-1:0]                   i_reg;
    logic [CW-1:0]                   i_next;
    logic [CW-1:0]                   pos_reg;
    logic [CW-1:0]                   pos_next;
    logic [4:0]                      n_reg;
    logic [4:0]                      n_next;
    logic [4:0]                      k_reg;
    logic [4:0]                      k_next;
    chrt_pkg::req_t                  req_reg;
    chrt_pkg::req_t                  req_next;
    logic [1:0]                      resp_status_reg;
    logic [1:0]                      resp_status_next;
    logic [chrt_pkg::TAG_W-1:0]      resp_tag_reg;
    logic [chrt_pkg::TAG_W-1:0]      resp_tag_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [1:0]                      out_status_reg;
    logic [1:0]                      out_status_next;
    logic [chrt_pkg::TAG_W-1:0]      out_tag_reg;
    logic [chrt_pkg::TAG_W-1:0]      out_tag_next;
    logic [chrt_pkg::HASH_W-1:0]     out_id_reg;
    logic [chrt_pkg::HASH_W-1:0]     out_id_next;
    logic                            out_last_reg;
    logic                            out_last_next;

    logic [chrt_pkg::HASH_W-1:0]     ids_mem [MAX_ENTRIES];
    logic [chrt_pkg::TAG_W-1:0]      tags_mem [MAX_ENTRIES];
    logic [chrt_pkg::HASH_W-1:0]     rd_id_reg;
    logic [chrt_pkg::TAG_W-1:0]      rd_tag_reg;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic                            we;
    logic [AW-1:0]                   waddr;
    logic [chrt_pkg::HASH_W-1:0]     wid;
    logic [chrt_pkg::TAG_W-1:0]      wtag;

    logic                            out_free;
    logic [CW-1:0]                   i_inc;
    logic [CW-1:0]                   i_dec;
    logic [XW-1:0]                   eff_cap;
    logic [XW-1:0]                   rep_min;
    logic [XW-1:0]                   rep_clamp;
    logic [4:0]                      n_calc;
    logic                            full;
    logic                            k_last;

    // effective capacity and replica count
    always_comb
    begin
        eff_cap = (XW'(table_capacity) < XW'(MAX_ENTRIES)) ? XW'(table_capacity)
                                                            : XW'(MAX_ENTRIES);
        rep_min = (XW'(replica_count) < eff_cap) ? XW'(replica_count) : eff_cap;
        rep_clamp = (rep_min < XW'(chrt_pkg::MAX_RESULTS)) ? rep_min
                                                            : XW'(chrt_pkg::MAX_RESULTS);
        n_calc = (rep_clamp == '0) ? 5'd1 : rep_clamp[4:0];
    end

    assign full = (XW'(count_reg) >= eff_cap);
    assign out_free = !out_valid_reg || !out_stall;
    assign i_inc = i_reg + CW'(1);
    assign i_dec = i_reg - CW'(1);
    assign k_last = ((k_reg + 5'd1) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next = i_reg;
        pos_next = pos_reg;
        n_next = n_reg;
        k_next = k_reg;
        req_next = req_reg;
        resp_status_next = resp_status_reg;
        resp_tag_next = resp_tag_reg;
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_tag_next = out_tag_reg;
        out_id_next = out_id_reg;
        out_last_next = out_last_reg;
        q_pop = 1'b0;
        rd_en = 1'b0;
        rd_addr = i_reg[AW-1:0];
        we = 1'b0;
        waddr = i_reg[AW-1:0];
        wid = rd_id_reg;
        wtag = rd_tag_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    req_next = q_req;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                i_next = '0;
                k_next = '0;
                n_next = n_calc;
                rd_addr = '0;
                if (req_reg.func == chrt_pkg::FUNC_REGISTER)
                begin
                    resp_tag_next = req_reg.tag;
                    if (full)
                    begin
                        resp_status_next = chrt_pkg::STATUS_FULL;
                        state_next = ST_RESP;
                    end
                    else if (count_reg == '0)
                    begin
                        pos_next = '0;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        state_next = ST_SRCH;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        resp_status_next = chrt_pkg::STATUS_EMPTY;
                        resp_tag_next = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SRCH:
            begin
                if (chrt_pkg::key_lt(rd_id_reg, req_reg.hash))
                begin
                    if (i_inc == count_reg)
                    begin
                        pos_next = count_reg;
                        i_next = count_reg;
                        state_next = ST_SHRD;
                    end
                    else
                    begin
                        i_next = i_inc;
                        rd_en = 1'b1;
                        rd_addr = i_inc[AW-1:0];
                    end
                end
                else if (rd_id_reg == req_reg.hash)
                begin
                    resp_status_next = chrt_pkg::STATUS_OK;
                    state_next = ST_RESP;
                end
                else
                begin
                    pos_next = i_reg;
                    i_next = count_reg;
                    state_next = ST_SHRD;
                end
            end
            ST_SHRD:
            begin
                if (i_reg == pos_reg)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = i_dec[AW-1:0];
                    state_next = ST_SHWR;
                end
            end
            ST_SHWR:
            begin
                we = 1'b1;
                i_next = i_dec;
                state_next = ST_SHRD;
            end
            ST_WRITE:
            begin
                we = 1'b1;
                waddr = pos_reg[AW-1:0];
                wid = req_reg.hash;
                wtag = req_reg.tag;
                count_next = count_reg + CW'(1);
                resp_status_next = chrt_pkg::STATUS_OK;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = resp_status_reg;
                    out_tag_next = resp_tag_reg;
                    out_id_next = req_reg.hash;
                    out_last_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!chrt_pkg::key_lt(req_reg.hash, rd_id_reg))
                begin
                    if (i_inc == count_reg)
                    begin
                        i_next = '0;
                        state_next = ST_LRD;
                    end
                    else
                    begin
                        i_next = i_inc;
                        rd_en = 1'b1;
                        rd_addr = i_inc[AW-1:0];
                    end
                end
                else
                begin
                    state_next = ST_LRD;
                end
            end
            ST_LRD:
            begin
                rd_en = 1'b1;
                state_next = ST_LOUT;
            end
            ST_LOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = chrt_pkg::STATUS_OK;
                    out_tag_next = rd_tag_reg;
                    out_id_next = rd_id_reg;
                    out_last_next = k_last;
                    k_next = k_reg + 5'd1;
                    i_next = (i_inc == count_reg) ? '0 : i_inc;
                    state_next = k_last ? ST_IDLE : ST_LRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        pos_reg <= pos_next;
        n_reg <= n_next;
        k_reg <= k_next;
        req_reg <= req_next;
        resp_status_reg <= resp_status_next;
        resp_tag_reg <= resp_tag_next;
        out_status_reg <= out_status_next;
        out_tag_reg <= out_tag_next;
        out_id_reg <= out_id_next;
        out_last_reg <= out_last_next;
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ids_mem[waddr] <= wid;
            tags_mem[waddr] <= wtag;
        end
        if (rd_en)
        begin
            rd_id_reg <= ids_mem[rd_addr];
            rd_tag_reg <= tags_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign entry_tag = out_tag_reg;
    assign entry_id = $signed(out_id_reg);
    assign last_result = out_last_reg;

endmodule
`default_nettype wire

// ----- sv/consistent_hash_ring_table_unit.sv -----
// top level: consistent hash ring table with config registers
// usage:
// - input beats carry one string byte each (func, key_byte, last_byte, slave_tag);
//   non-final bytes are hashed at one beat per cycle while in_stall is low
// - a final byte hands the request to a two-entry queue; in_stall rises while it is full
// - register: linear search of the sorted table, then a shift (SHRD read, SHWR write)
//   per entry moved, one write, one result beat; a duplicate answers OK, no write
// - lookup: linear scan, then a read (LRD) and an output (LOUT) per result beat,
//   replica count clamped to capacity beats in all; the entry memory read is registered
// - a request that finds the table full or empty answers through START and RESP
// - results leave through an output register; out_stall holds it and the
//   engine waits, while the front end keeps hashing until the queue fills
// - config writes (cfg_we, cfg_index, cfg_data) are registered; the user must
//   write them only while idle, which the block itself does not enforce
// - reset: hash back to the seed, table empty, capacity 16, replica count 3
`default_nettype none
module consistent_hash_ring_table_unit
#(
    parameter int MAX_ENTRIES = chrt_pkg::MAX_ENTRIES_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [chrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [chrt_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic [7:0]                          key_byte,
    input  wire logic                                last_byte,
    input  wire logic [chrt_pkg::TAG_W-1:0]          slave_tag,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               status,
    output logic [chrt_pkg::TAG_W-1:0]               entry_tag,
    output logic signed [chrt_pkg::HASH_W-1:0]       entry_id,
    output logic                                     last_result
);

    logic [chrt_pkg::CFG_W-1:0] capacity_reg;
    logic [chrt_pkg::CFG_W-1:0] capacity_next;
    logic [chrt_pkg::CFG_W-1:0] replica_reg;
    logic [chrt_pkg::CFG_W-1:0] replica_next;

    logic            q_full;
    logic            q_push;
    chrt_pkg::req_t  q_push_req;
    logic            q_valid;
    logic            q_pop;
    chrt_pkg::req_t  q_head;

    always_comb
    begin
        capacity_next = capacity_reg;
        replica_next = replica_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                chrt_pkg::REG_CAPACITY: capacity_next = cfg_data;
                chrt_pkg::REG_REPLICA:  replica_next = cfg_data;
                default:                capacity_next = capacity_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= chrt_pkg::CAPACITY_RESET;
            replica_reg <= chrt_pkg::REPLICA_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
            replica_reg <= replica_next;
        end
    end

    chrt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .key_byte  (key_byte),
        .last_byte (last_byte),
        .slave_tag (slave_tag),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_req     (q_push_req)
    );

    chrt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_push_req),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    chrt_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .table_capacity (capacity_reg),
        .replica_count  (replica_reg),
        .q_valid        (q_valid),
        .q_req          (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_tag      (entry_tag),
        .entry_id       (entry_id),
        .last_result    (last_result)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the consistent hash ring table unit
module tb_top;
    import chrt_pkg::*;

    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic             func;
        logic [7:0]       key_byte;
        logic             last_byte;
        logic [TAG_W-1:0] slave_tag;
    } beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  tag;
        logic [HASH_W-1:0] id;
        logic              last;
    } ring_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = FUNC_REGISTER;
    logic [7:0] key_byte = 8'h00;
    logic last_byte = 1'b0;
    logic [TAG_W-1:0] slave_tag = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [TAG_W-1:0] entry_tag;
    logic signed [HASH_W-1:0] entry_id;
    logic last_result;

    // ring model state
    logic [HASH_W-1:0] ring_hash = HASH_SEED;
    logic [HASH_W-1:0] ring_ids[MAX_ENTRIES_DEF];
    logic [TAG_W-1:0] ring_tags[MAX_ENTRIES_DEF];
    int ring_count = 0;
    int capacity = 16;
    int replicas = 3;

    beat_t pending_beats[$];
    beat_t offered;
    ring_result_t ring_results[$];
    ring_result_t want;
    logic [63:0] key_pool[$];
    int key_len_pool[$];

    int send_gap = 0;
    int recv_gap = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_request = 1'b0;
    int quiet_cycles = 0;

    int mismatch_count = 0;
    int beats_taken = 0;
    int results_checked = 0;
    int n_register = 0;
    int n_lookup = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_dup = 0;
    int settings_seen = 1;

    consistent_hash_ring_table_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .key_byte    (key_byte),
        .last_byte   (last_byte),
        .slave_tag   (slave_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_tag   (entry_tag),
        .entry_id    (entry_id),
        .last_result (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_result(input logic [1:0] st, input logic [TAG_W-1:0] tag,
                                       input logic [HASH_W-1:0] id, input logic last);
        ring_result_t r;
        r.status = st;
        r.tag = tag;
        r.id = id;
        r.last = last;
        ring_results.push_back(r);
    endfunction

    function automatic int effective_capacity();
        return (capacity < MAX_ENTRIES_DEF) ? capacity : MAX_ENTRIES_DEF;
    endfunction

    function automatic void insert_key(input logic [HASH_W-1:0] h, input logic [TAG_W-1:0] tag);
        int pos;
        pos = 0;
        n_register++;
        if (ring_count >= effective_capacity())
        begin
            n_full++;
            add_result(STATUS_FULL, tag, h, 1'b1);
            return;
        end
        while (pos < ring_count && $signed(ring_ids[pos]) < $signed(h))
            pos++;
        if (pos < ring_count && ring_ids[pos] == h)
            n_dup++;
        else
        begin
            for (int i = ring_count; i > pos; i--)
            begin
                ring_ids[i] = ring_ids[i - 1];
                ring_tags[i] = ring_tags[i - 1];
            end
            ring_ids[pos] = h;
            ring_tags[pos] = tag;
            ring_count++;
        end
        add_result(STATUS_OK, tag, h, 1'b1);
    endfunction

    function automatic void walk_ring(input logic [HASH_W-1:0] h);
        int idx;
        int n;
        idx = 0;
        n_lookup++;
        if (ring_count == 0)
        begin
            n_empty++;
            add_result(STATUS_EMPTY, '0, h, 1'b1);
            return;
        end
        while (idx < ring_count && $signed(ring_ids[idx]) <= $signed(h))
            idx++;
        if (idx >= ring_count)
            idx = 0;
        n = replicas;
        if (n > effective_capacity())
            n = effective_capacity();
        if (n > MAX_RESULTS)
            n = MAX_RESULTS;
        if (n == 0)
            n = 1;
        for (int k = 0; k < n; k++)
        begin
            add_result(STATUS_OK, ring_tags[idx], ring_ids[idx], k + 1 == n);
            idx++;
            if (idx >= ring_count)
                idx = 0;
        end
    endfunction

    function automatic void take_beat(input beat_t b);
        logic [HASH_W-1:0] h;
        ring_hash = ring_hash * 64'd31 + {{56{b.key_byte[7]}}, b.key_byte};
        if (!b.last_byte)
            return;
        h = ring_hash;
        ring_hash = HASH_SEED;
        if (b.func == FUNC_REGISTER)
            insert_key(h, b.slave_tag);
        else
            walk_ring(h);
    endfunction

    // input side: beats leave the queue, held while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                take_beat(offered);
                beats_taken++;
                send_gap = draw_gap(send_idle_pct);
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_beats.size() != 0)
                begin
                    offered = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    func <= offered.func;
                    key_byte <= offered.key_byte;
                    last_byte <= offered.last_byte;
                    slave_tag <= offered.slave_tag;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: check each result beat, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (ring_results.size() == 0)
                begin
                    $display("%0t: unexpected result: status %0d tag %h id %h last %b", $time,
                             status, entry_tag, entry_id, last_result);
                    mismatch_count++;
                end
                else
                begin
                    want = ring_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, status);
                        mismatch_count++;
                    end
                    if (entry_tag !== want.tag)
                    begin
                        $display("%0t: entry_tag expected %h got %h", $time, want.tag, entry_tag);
                        mismatch_count++;
                    end
                    if (entry_id !== want.id)
                    begin
                        $display("%0t: entry_id expected %h got %h", $time, want.id, entry_id);
                        mismatch_count++;
                    end
                    if (last_result !== want.last)
                    begin
                        $display("%0t: last_result expected %b got %b", $time, want.last,
                                 last_result);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                recv_gap = LONG_HOLD;
            end
            else if (recv_gap == 0)
                recv_gap = draw_gap(recv_idle_pct);
            out_stall <= (recv_gap != 0);
            if (recv_gap != 0)
                recv_gap--;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic add_string(input logic fn, input logic [63:0] text, input int len,
                              input logic [TAG_W-1:0] tag);
        beat_t b;
        for (int i = 0; i < len; i++)
        begin
            b.func = (i == len - 1) ? fn : 1'($urandom_range(1));
            b.key_byte = text[8*i +: 8];
            b.last_byte = (i == len - 1);
            b.slave_tag = (i == len - 1) ? tag : TAG_W'($urandom);
            pending_beats.push_back(b);
        end
        if (fn == FUNC_REGISTER)
        begin
            key_pool.push_back(text);
            key_len_pool.push_back(len);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || ring_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input int cap, input int rep);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_data <= CFG_W'(cap);
        @(posedge clk);
        cfg_index <= REG_REPLICA;
        cfg_data <= CFG_W'(rep);
        @(posedge clk);
        cfg_we <= 1'b0;
        capacity = cap;
        replicas = rep;
        settings_seen++;
    endtask

    task automatic run_phase(input int beats, input int send_pct, input int recv_pct,
                             input logic long_hold);
        int added;
        int pick;
        int j;
        int len;
        logic [63:0] text;
        added = 0;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (added < beats)
        begin
            pick = $urandom_range(99);
            j = $urandom_range(key_pool.size() - 1);
            text = {$urandom, $urandom};
            len = $urandom_range(1, 8);
            if (pick < 40)
                add_string(FUNC_REGISTER, text, len, TAG_W'($urandom));
            else if (pick < 80)
            begin
                len = key_len_pool[j];
                add_string((pick < 50) ? FUNC_REGISTER : FUNC_LOOKUP, key_pool[j], len,
                           TAG_W'($urandom));
            end
            else
                add_string(FUNC_LOOKUP, text, len, TAG_W'($urandom));
            added += len;
        end
        if (long_hold)
            hold_request = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, byte extremes, duplicate, mixed kinds, exact-hit lookup
        send_idle_pct = 20;
        recv_idle_pct = 20;
        add_string(FUNC_LOOKUP, 64'h00, 1, 16'h0000);
        add_string(FUNC_REGISTER, 64'hFF, 1, 16'hFFFF);
        add_string(FUNC_REGISTER, 64'h7F80, 2, 16'h0000);
        add_string(FUNC_REGISTER, 64'hFF, 1, 16'h1234);
        add_string(FUNC_REGISTER, 64'h434241, 3, 16'hA5A5);
        add_string(FUNC_LOOKUP, 64'hFF, 1, 16'h0F0F);
        add_string(FUNC_LOOKUP, 64'h80FF00, 3, 16'hF0F0);
        add_string(FUNC_REGISTER, 64'h01FE7F80, 4, 16'h5A5A);

        // capacity below the count: registers full, lookups clamped to capacity beats
        set_config(3, 16);
        add_string(FUNC_REGISTER, 64'hFF, 1, 16'h0001);
        add_string(FUNC_REGISTER, 64'h55, 1, 16'h0002);
        add_string(FUNC_LOOKUP, 64'h41, 1, 16'h0003);
        set_config(1, 1);
        add_string(FUNC_REGISTER, 64'h66, 1, 16'h0004);
        add_string(FUNC_LOOKUP, 64'h434241, 3, 16'h0005);

        set_config(16, 16);
        run_phase(45, 20, 20, 1'b0);
        set_config(16, 1);
        run_phase(40, 0, 0, 1'b0);
        set_config(8, 3);
        run_phase(45, 0, 30, 1'b1);
        set_config(16, 5);
        run_phase(45, 50, 10, 1'b0);
        set_config(2, 16);
        run_phase(40, 10, 40, 1'b0);
        set_config($urandom_range(1, 16), $urandom_range(1, 16));
        run_phase(45, 20, 20, 1'b0);

        wait_idle();
        if (ring_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, ring_results.size());
            mismatch_count += ring_results.size();
        end
        $display("tb_top: %0d byte beats, %0d register and %0d lookup requests, %0d results",
                 beats_taken, n_register, n_lookup, results_checked);
        $display("tb_top: %0d full, %0d empty, %0d duplicate, %0d settings, %0d entries",
                 n_full, n_empty, n_dup, settings_seen, ring_count);
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/chrt_pkg.sv
sv/chrt_front.sv
sv/chrt_queue.sv
sv/chrt_back.sv
sv/consistent_hash_ring_table_unit.sv
tb/sv/tb_top.sv
